@@ sv/omw_pkg.sv @@
// ----------------------------------------------------------------------------
// omw_pkg: shared types and constants for the ordinate weight mapper
// Fixed field widths, fixed-point constants, sequencer states, register codes
// and the request and status bundles of the serial divider.
// ----------------------------------------------------------------------------
package omw_pkg;

    // Field widths
    localparam int COS_W   = 16;   // Q2.14 cosine
    localparam int WGT_W   = 24;   // Q8.16 weight
    localparam int IDX_W   = 6;    // entry index field
    localparam int OWGT_W  = 32;   // Q16.16 result weight
    localparam int SIZE_W  = 7;    // set_size register
    localparam int TOL_W   = 29;   // coincide_tol register
    localparam int CFG_A_W = 3;    // configuration register index
    localparam int CFG_D_W = 29;   // configuration write data

    // Stream payload widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    // Dot product and distance arithmetic
    localparam int DOT_W  = 31;
    localparam int ACC_W  = 2 * COS_W + 2;
    localparam int DIST_W = 29;
    localparam int P_W    = 2 * DIST_W - 1;    // distance product, at most 2^56
    localparam int SUM_W  = P_W + 1;
    localparam int SHARE_W = 33;               // Q1.32 share, up to 1.0
    localparam int MUL_W  = 34;                // signed operand of shared multiplier
    localparam int MULP_W = 2 * MUL_W;
    localparam int NUM_W  = 57;                // weight times share

    localparam logic signed [ACC_W-1:0] DOT_MAX = ACC_W'(64'sd1073741823);
    localparam logic signed [ACC_W-1:0] DOT_MIN = ACC_W'(-64'sd1073741824);
    localparam logic signed [DOT_W-1:0] DOT_NEG_ONE = DOT_W'(-64'sd268435456);
    localparam logic signed [DOT_W-1:0] DOT_ONE = DOT_W'(64'sd268435456);
    localparam logic [SHARE_W-1:0] SHARE_ONE = {1'b1, {(SHARE_W-1){1'b0}}};
    localparam logic [OWGT_W-1:0]  WGT_SAT   = '1;

    // Serial divider
    localparam int DIV_R_W = SUM_W;            // divisor and remainder width
    localparam int DIV_Q_W = NUM_W - 16;       // quotient and dividend width
    localparam int STEP_W  = 6;
    localparam logic [STEP_W-1:0] SHARE_STEPS  = STEP_W'(SHARE_W);
    localparam logic [STEP_W-1:0] WEIGHT_STEPS = STEP_W'(DIV_Q_W);

    typedef struct packed {
        logic                start;
        logic [DIV_R_W-1:0]  rem_init;
        logic [DIV_R_W-1:0]  divisor;
        logic [DIV_Q_W-1:0]  dividend;
        logic [STEP_W-1:0]   steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Input opcodes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MAP  = 1'b1
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_INTERP     = 3'd0,
        CFG_ONE_D      = 3'd1,
        CFG_START_DIRS = 3'd2,
        CFG_SET_SIZE   = 3'd3,
        CFG_TOL        = 3'd4
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_RANK,
        ST_DIST,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_SUM,
        ST_SDIV,
        ST_SWAIT,
        ST_WRD,
        ST_WMUL,
        ST_WDIV,
        ST_WWAIT,
        ST_OUT
    } t_state;

endpackage

@@ sv/ordinate_weight_mapper.sv @@
// ----------------------------------------------------------------------------
// ordinate_weight_mapper: maps a direction and weight onto a quadrature table
// Load transactions fill the table; a map transaction scans it, ranks the
// best entries and emits one or three scaled weights.
// ----------------------------------------------------------------------------
// Flow: a load is written into the table when it is accepted. A map reads each
// scanned table entry in turn (read, three multiplies through one shared
// multiplier, rank), then produces each result by serial division; nearest-three
// adds the share divisions unless a near coincidence gives one entry all weight.
// Throughput: one transaction at a time; the input is not ready until the
// final result has been taken. Reset clears control state and config only.
module ordinate_weight_mapper #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [omw_pkg::CFG_A_W-1:0]        i_cfg_addr,
    input  logic [omw_pkg::CFG_D_W-1:0]        i_cfg_data,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index[5:0], cos_mu[21:6], cos_eta[37:22], cos_xi[53:38],
    // dir_weight[77:54], zero pad [79:78]
    input  logic [omw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode[0]
    input  logic                               s_axis_tuser,
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_index[5:0], out_weight[37:6], zero pad [39:38]
    output logic [omw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SZ_W  = (CNT_W > omw_pkg::SIZE_W) ? CNT_W : omw_pkg::SIZE_W;
    localparam int ENT_W = 3 * omw_pkg::COS_W + omw_pkg::WGT_W;

    typedef logic signed [omw_pkg::DOT_W-1:0] t_dot;

    // Configuration
    logic                        r_interp;
    logic                        r_one_d;
    logic                        r_start_dirs;
    logic [omw_pkg::SIZE_W-1:0]  r_set_size;
    logic [omw_pkg::TOL_W-1:0]   r_tol;

    // Sequencer
    omw_pkg::t_state r_state, n_state;

    // Latched map transaction
    logic signed [omw_pkg::COS_W-1:0] r_mu, r_eta, r_xi;
    logic [omw_pkg::WGT_W-1:0]        r_w_in;

    // Table
    logic [ENT_W-1:0] mem [MAX_ENTRIES];
    logic [ENT_W-1:0] r_rd_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    // Scan and rank
    logic [AW-1:0]                    r_i;
    logic signed [omw_pkg::ACC_W-1:0] r_acc;
    t_dot                             r_best [3];
    logic [AW-1:0]                    r_best_idx [3];
    logic [1:0]                       r_cnt;
    logic [1:0]                       r_k;

    // Shared multiplier
    logic signed [omw_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [omw_pkg::MULP_W-1:0] r_prod;

    // Shares and divisions
    logic [omw_pkg::P_W-1:0]     r_p [3];
    logic [omw_pkg::SUM_W-1:0]   r_sum;
    logic [omw_pkg::SHARE_W-1:0] r_share [3];
    logic                        r_num_nz;
    omw_pkg::t_div_req           div_req;
    omw_pkg::t_div_stat          div_stat;
    logic [omw_pkg::DIV_Q_W-1:0] div_quot;

    // Output register
    logic                         r_out_valid;
    logic [omw_pkg::IDX_W-1:0]    r_out_idx;
    logic [omw_pkg::OWGT_W-1:0]   r_out_weight;
    logic                         r_out_last;

    // Combinational helpers
    logic                              in_acc;
    logic [AW-1:0]                     ld_addr;
    logic [SZ_W-1:0]                   n_eff;
    logic                              scan_last;
    logic [omw_pkg::WGT_W-1:0]         ent_w;
    logic signed [omw_pkg::COS_W-1:0]  ent_mu, ent_eta, ent_xi;
    t_dot                              d_rank;
    logic                              gt0, gt1, gt2;
    logic [omw_pkg::DIST_W-1:0]        gap [3];
    logic                              all_far;
    logic [1:0]                        pick;
    logic                              res_last;

    function automatic logic [omw_pkg::DIST_W-1:0] dist_of(input t_dot c);
        t_dot cc;
        cc = c;
        if (cc < 0) cc = '0;
        if (cc > omw_pkg::DOT_ONE) cc = omw_pkg::DOT_ONE;
        return omw_pkg::DIST_W'(omw_pkg::DOT_ONE - cc);
    endfunction

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign ld_addr = AW'(s_axis_tdata[5:0]);

    // Table entry fields: {weight, xi, eta, mu}
    assign ent_mu  = r_rd_data[15:0];
    assign ent_eta = r_rd_data[31:16];
    assign ent_xi  = r_rd_data[47:32];
    assign ent_w   = r_rd_data[71:48];

    // Entries scanned, held within three and the table depth
    always_comb begin
        n_eff = SZ_W'(r_set_size);
        if (n_eff > SZ_W'(MAX_ENTRIES)) n_eff = SZ_W'(MAX_ENTRIES);
        if (n_eff < SZ_W'(3)) n_eff = SZ_W'(3);
        scan_last = (SZ_W'(r_i) == n_eff - SZ_W'(1));
    end

    // Saturate the dot, force zero-weight start directions to minus one, and place it against the ranking
    always_comb begin
        if (r_acc > omw_pkg::DOT_MAX)
            d_rank = omw_pkg::DOT_W'(omw_pkg::DOT_MAX);
        else if (r_acc < omw_pkg::DOT_MIN)
            d_rank = omw_pkg::DOT_W'(omw_pkg::DOT_MIN);
        else
            d_rank = omw_pkg::DOT_W'(r_acc);
        if (r_start_dirs && (ent_w == '0))
            d_rank = omw_pkg::DOT_NEG_ONE;
        gt0 = (r_cnt == 2'd0) || (d_rank > r_best[0]);
        gt1 = (r_cnt <  2'd2) || (d_rank > r_best[1]);
        gt2 = (r_cnt <  2'd3) || (d_rank > r_best[2]);
    end

    // Distances and coincidence pick
    always_comb begin
        for (int k = 0; k < 3; k++)
            gap[k] = dist_of(r_best[k]);
        all_far = (gap[0] > r_tol) && (gap[1] > r_tol) && (gap[2] > r_tol);
        if (gap[0] <= r_tol)
            pick = 2'd0;
        else if (gap[1] <= r_tol)
            pick = 2'd1;
        else
            pick = 2'd2;
    end

    assign res_last = r_interp ? (r_k == 2'd2) : 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp     <= 1'b0;
            r_one_d      <= 1'b0;
            r_start_dirs <= 1'b0;
            r_set_size   <= omw_pkg::SIZE_W'(64);
            r_tol        <= omw_pkg::TOL_W'(268);
        end else if (i_cfg_we) begin
            unique case (omw_pkg::t_cfg_reg'(i_cfg_addr))
                omw_pkg::CFG_INTERP:     r_interp     <= i_cfg_data[0];
                omw_pkg::CFG_ONE_D:      r_one_d      <= i_cfg_data[0];
                omw_pkg::CFG_START_DIRS: r_start_dirs <= i_cfg_data[0];
                omw_pkg::CFG_SET_SIZE:   r_set_size   <= i_cfg_data[omw_pkg::SIZE_W-1:0];
                omw_pkg::CFG_TOL:        r_tol        <= i_cfg_data[omw_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Table memory: write on load, registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && (omw_pkg::t_opcode'(s_axis_tuser) == omw_pkg::OP_LOAD) &&
            (32'(s_axis_tdata[5:0]) < MAX_ENTRIES))
            mem[ld_addr] <= {s_axis_tdata[77:54], s_axis_tdata[53:38],
                             s_axis_tdata[37:22], s_axis_tdata[21:6]};
        if (rd_en)
            r_rd_data <= mem[rd_addr];
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            omw_pkg::ST_M0: begin
                mul_a = omw_pkg::MUL_W'(r_mu);
                mul_b = omw_pkg::MUL_W'(ent_mu);
            end
            omw_pkg::ST_M1: begin
                mul_a = omw_pkg::MUL_W'(r_eta);
                mul_b = omw_pkg::MUL_W'(ent_eta);
            end
            omw_pkg::ST_M2: begin
                mul_a = omw_pkg::MUL_W'(r_xi);
                mul_b = omw_pkg::MUL_W'(ent_xi);
            end
            omw_pkg::ST_P0: begin
                mul_a = omw_pkg::MUL_W'(gap[1]);
                mul_b = omw_pkg::MUL_W'(gap[2]);
            end
            omw_pkg::ST_P1: begin
                mul_a = omw_pkg::MUL_W'(gap[0]);
                mul_b = omw_pkg::MUL_W'(gap[2]);
            end
            omw_pkg::ST_P2: begin
                mul_a = omw_pkg::MUL_W'(gap[0]);
                mul_b = omw_pkg::MUL_W'(gap[1]);
            end
            omw_pkg::ST_WMUL: begin
                mul_a = omw_pkg::MUL_W'(r_w_in);
                mul_b = omw_pkg::MUL_W'(r_share[r_k]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= omw_pkg::ST_IDLE;
        else
            r_state <= n_state;
    end

    // Next state, memory reads and divider requests
    always_comb begin
        n_state          = r_state;
        rd_en            = 1'b0;
        rd_addr          = r_i;
        div_req          = '0;
        s_axis_tready    = 1'b0;
        unique case (r_state)
            omw_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc && (omw_pkg::t_opcode'(s_axis_tuser) == omw_pkg::OP_MAP))
                    n_state = omw_pkg::ST_RD;
            end
            omw_pkg::ST_RD: begin
                rd_en   = 1'b1;
                n_state = omw_pkg::ST_M0;
            end
            omw_pkg::ST_M0: n_state = omw_pkg::ST_M1;
            omw_pkg::ST_M1: n_state = omw_pkg::ST_M2;
            omw_pkg::ST_M2: n_state = omw_pkg::ST_M3;
            omw_pkg::ST_M3: n_state = omw_pkg::ST_RANK;
            omw_pkg::ST_RANK: begin
                if (!scan_last)
                    n_state = omw_pkg::ST_RD;
                else if (r_interp)
                    n_state = omw_pkg::ST_DIST;
                else
                    n_state = omw_pkg::ST_WRD;
            end
            omw_pkg::ST_DIST: n_state = all_far ? omw_pkg::ST_P0 : omw_pkg::ST_WRD;
            omw_pkg::ST_P0:   n_state = omw_pkg::ST_P1;
            omw_pkg::ST_P1:   n_state = omw_pkg::ST_P2;
            omw_pkg::ST_P2:   n_state = omw_pkg::ST_SUM;
            omw_pkg::ST_SUM:  n_state = omw_pkg::ST_SDIV;
            omw_pkg::ST_SDIV: begin
                div_req.start    = 1'b1;
                div_req.rem_init = omw_pkg::DIV_R_W'(r_p[r_k] >> 1);
                div_req.divisor  = r_sum;
                div_req.dividend = {r_p[r_k][0], {(omw_pkg::DIV_Q_W-1){1'b0}}};
                div_req.steps    = omw_pkg::SHARE_STEPS;
                n_state          = omw_pkg::ST_SWAIT;
            end
            omw_pkg::ST_SWAIT: begin
                if (div_stat.done && !div_stat.busy)
                    n_state = (r_k == 2'd2) ? omw_pkg::ST_WRD : omw_pkg::ST_SDIV;
            end
            omw_pkg::ST_WRD: begin
                rd_en   = 1'b1;
                rd_addr = r_best_idx[r_k];
                n_state = omw_pkg::ST_WMUL;
            end
            omw_pkg::ST_WMUL: n_state = omw_pkg::ST_WDIV;
            omw_pkg::ST_WDIV: begin
                div_req.start    = 1'b1;
                div_req.rem_init = '0;
                div_req.divisor  = omw_pkg::DIV_R_W'(ent_w);
                div_req.dividend = r_prod[omw_pkg::NUM_W-1:16];
                div_req.steps    = omw_pkg::WEIGHT_STEPS;
                n_state          = omw_pkg::ST_WWAIT;
            end
            omw_pkg::ST_WWAIT: begin
                if (div_stat.done && !div_stat.busy)
                    n_state = omw_pkg::ST_OUT;
            end
            omw_pkg::ST_OUT: begin
                if (m_axis_tready)
                    n_state = r_out_last ? omw_pkg::ST_IDLE : omw_pkg::ST_WRD;
            end
            default: n_state = omw_pkg::ST_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_best[k]     <= '0;
                r_best_idx[k] <= '0;
            end
        end else begin
            unique case (r_state)
                omw_pkg::ST_IDLE: begin
                    r_mu   <= s_axis_tdata[21:6];
                    r_eta  <= s_axis_tdata[37:22];
                    r_xi   <= s_axis_tdata[53:38];
                    r_w_in <= s_axis_tdata[77:54];
                    r_i    <= '0;
                    r_cnt  <= '0;
                    r_k    <= '0;
                end
                omw_pkg::ST_M1: r_acc <= omw_pkg::ACC_W'(r_prod);
                omw_pkg::ST_M2: if (!r_one_d) r_acc <= r_acc + omw_pkg::ACC_W'(r_prod);
                omw_pkg::ST_M3: if (!r_one_d) r_acc <= r_acc + omw_pkg::ACC_W'(r_prod);
                omw_pkg::ST_RANK: begin
                    // Insert the dot, ties keep the earlier entry
                    if (gt0) begin
                        r_best[2]     <= r_best[1];
                        r_best_idx[2] <= r_best_idx[1];
                        r_best[1]     <= r_best[0];
                        r_best_idx[1] <= r_best_idx[0];
                        r_best[0]     <= d_rank;
                        r_best_idx[0] <= r_i;
                    end else if (gt1) begin
                        r_best[2]     <= r_best[1];
                        r_best_idx[2] <= r_best_idx[1];
                        r_best[1]     <= d_rank;
                        r_best_idx[1] <= r_i;
                    end else if (gt2) begin
                        r_best[2]     <= d_rank;
                        r_best_idx[2] <= r_i;
                    end
                    if (r_cnt != 2'd3)
                        r_cnt <= r_cnt + 2'd1;
                    r_i <= r_i + 1'b1;
                    if (scan_last && !r_interp)
                        r_share[0] <= omw_pkg::SHARE_ONE;
                end
                omw_pkg::ST_DIST: begin
                    // Near coincidence gives the whole weight to one entry
                    if (!all_far)
                        for (int k = 0; k < 3; k++)
                            r_share[k] <= (pick == 2'(k)) ? omw_pkg::SHARE_ONE : '0;
                end
                omw_pkg::ST_P1:  r_p[0] <= r_prod[omw_pkg::P_W-1:0];
                omw_pkg::ST_P2:  r_p[1] <= r_prod[omw_pkg::P_W-1:0];
                omw_pkg::ST_SUM: begin
                    r_p[2] <= r_prod[omw_pkg::P_W-1:0];
                    r_sum  <= omw_pkg::SUM_W'(r_p[0]) + omw_pkg::SUM_W'(r_p[1]) +
                              omw_pkg::SUM_W'(r_prod[omw_pkg::P_W-1:0]);
                end
                omw_pkg::ST_SWAIT: begin
                    if (div_stat.done && !div_stat.busy) begin
                        r_share[r_k] <= div_quot[omw_pkg::SHARE_W-1:0];
                        r_k          <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    end
                end
                omw_pkg::ST_WDIV: r_num_nz <= (r_prod[omw_pkg::NUM_W-1:0] != '0);
                omw_pkg::ST_WWAIT: begin
                    if (div_stat.done && !div_stat.busy) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= omw_pkg::IDX_W'(r_best_idx[r_k]);
                        r_out_last  <= res_last;
                        if (ent_w == '0)
                            r_out_weight <= r_num_nz ? omw_pkg::WGT_SAT : '0;
                        else if (div_quot[omw_pkg::DIV_Q_W-1:omw_pkg::OWGT_W] != '0)
                            r_out_weight <= omw_pkg::WGT_SAT;
                        else
                            r_out_weight <= div_quot[omw_pkg::OWGT_W-1:0];
                    end
                end
                omw_pkg::ST_OUT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_k         <= r_k + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    omw_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_weight, r_out_idx};
    assign m_axis_tlast  = r_out_last;

endmodule

@@ sv/omw_divider.sv @@
// ----------------------------------------------------------------------------
// omw_divider: restoring serial divider
// One quotient bit per cycle; the remainder starts from a given value and the
// dividend bits are shifted in from the top for a given number of steps.
// ----------------------------------------------------------------------------
module omw_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  omw_pkg::t_div_req                   i_req,
    output omw_pkg::t_div_stat                  o_stat,
    output logic [omw_pkg::DIV_Q_W-1:0]         o_quot
);

    logic [omw_pkg::DIV_R_W-1:0] r_rem;
    logic [omw_pkg::DIV_R_W-1:0] r_div;
    logic [omw_pkg::DIV_Q_W-1:0] r_dvd;
    logic [omw_pkg::DIV_Q_W-1:0] r_quot;
    logic [omw_pkg::STEP_W-1:0]  r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [omw_pkg::DIV_R_W:0]   trial;
    logic [omw_pkg::DIV_R_W:0]   diff;
    logic                        fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_dvd[omw_pkg::DIV_Q_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    // Advance one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_div  <= i_req.divisor;
            r_dvd  <= i_req.dividend;
            r_quot <= '0;
            r_cnt  <= i_req.steps;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[omw_pkg::DIV_R_W-1:0] : trial[omw_pkg::DIV_R_W-1:0];
            r_quot <= {r_quot[omw_pkg::DIV_Q_W-2:0], fits};
            r_dvd  <= {r_dvd[omw_pkg::DIV_Q_W-2:0], 1'b0};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == omw_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

@@ sv/omw_checker.sv @@
// ----------------------------------------------------------------------------
// omw_checker: port-level checks for the ordinate weight mapper
// Watches both stream handshakes and the reset over time.
// ----------------------------------------------------------------------------
module omw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);

    // Hold off input while a result waits
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    // Keep a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before its transaction");

    // Drop output valid after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // Return to ready once the final result is taken
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("input not ready after final result");

endmodule

bind ordinate_weight_mapper omw_checker u_omw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);
